>>> sv/ctcs_pkg.sv
// ----------------------------------------------------------------------------
// ctcs_pkg
// shared types, widths and helpers of the circle tile-map collision step
// ----------------------------------------------------------------------------
package ctcs_pkg;

   localparam int MAP_SIDE_DEF = 32;
   localparam int MAP_CELLS    = 1024;
   localparam int ADDR_W       = 10;
   localparam int POS_W        = 21;
   localparam int COORD_W      = 24;
   localparam int WIN_W        = 7;
   localparam int RAD_W        = 16;
   localparam int SPD_W        = 12;
   localparam int DT_W         = 16;
   localparam int DIST_W       = 17;
   localparam int SQ_IN_W      = 46;
   localparam int SQ_ROOT_W    = 23;
   localparam int SQ_REM_W     = 26;
   localparam int DV_NUM_W     = 33;
   localparam int DV_DEN_W     = 16;
   localparam int DV_Q_W       = 17;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 16;

   localparam logic [POS_W-1:0]  POS_MAX      = 21'h1FFFFF;
   localparam logic [POS_W-1:0]  CENTRE_RESET = 21'd196608;
   localparam logic [POS_W-1:0]  HALF_TILE    = 21'd32768;
   localparam logic [DIST_W-1:0] ONE_TILE     = 17'd65536;
   localparam logic [15:0]       INV_SQRT2    = 16'd46341;
   localparam logic [RAD_W-1:0]  RADIUS_RESET = 16'd32768;
   localparam logic [SPD_W-1:0]  SPD_N_RESET  = 12'd512;
   localparam logic [SPD_W-1:0]  SPD_F_RESET  = 12'd1280;

   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_NORM = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_FAST = 2'd2;

   localparam logic OP_TILE = 1'b0;
   localparam logic OP_MOVE = 1'b1;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic              wdata;
   } mem_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

   function automatic logic [POS_W-1:0] sat_pos(input logic signed [COORD_W-1:0] v);
      logic [POS_W-1:0] r;
      if (v < 0) r = '0;
      else if (v > $signed({{(COORD_W-POS_W){1'b0}}, POS_MAX})) r = POS_MAX;
      else r = v[POS_W-1:0];
      return r;
   endfunction

   function automatic logic signed [1:0] dir_of(input logic [1:0] raw);
      logic signed [1:0] d;
      case (raw)
         2'b01:   d = 2'sb01;
         2'b00:   d = 2'sb00;
         default: d = 2'sb11;
      endcase
      return d;
   endfunction

endpackage

>>> sv/ctcs_tile_mem.sv
// ----------------------------------------------------------------------------
// ctcs_tile_mem
// one-bit solid-tile map, single port, registered read
// ----------------------------------------------------------------------------
module ctcs_tile_mem (
   input  logic                 clock,
   input  ctcs_pkg::mem_req_type mem_req,
   output logic                 rd_data
);
   import ctcs_pkg::*;

   logic mem_ff [MAP_CELLS];

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem_ff[mem_req.addr] <= mem_req.wdata;
      end
      rd_data <= mem_ff[mem_req.addr];
   end

endmodule

>>> sv/ctcs_isqrt.sv
// ----------------------------------------------------------------------------
// ctcs_isqrt
// floor square root, two radicand bits per cycle
// ----------------------------------------------------------------------------
module ctcs_isqrt (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [ctcs_pkg::SQ_IN_W-1:0]    radicand,
   output logic [ctcs_pkg::SQ_ROOT_W-1:0]  root,
   output ctcs_pkg::unit_stat_type         stat
);
   import ctcs_pkg::*;

   localparam int STEPS = SQ_IN_W / 2;
   localparam int CNT_W = $clog2(STEPS + 1);

   logic [SQ_IN_W-1:0]   rad_ff, rad_in;
   logic [SQ_REM_W-1:0]  rem_ff, rem_in;
   logic [SQ_ROOT_W-1:0] root_ff, root_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 busy_ff, busy_in, done_ff, done_in;
   logic [SQ_REM_W-1:0]  rem_t, trial;

   always_comb begin
      rem_t   = {rem_ff[SQ_REM_W-3:0], rad_ff[SQ_IN_W-1 -: 2]};
      trial   = {{(SQ_REM_W-SQ_ROOT_W-2){1'b0}}, root_ff, 2'b01};
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_W'(STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[SQ_IN_W-3:0], 2'b00};
         if (rem_t >= trial) begin
            rem_in  = rem_t - trial;
            root_in = {root_ff[SQ_ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_t;
            root_in = {root_ff[SQ_ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root      = root_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

>>> sv/ctcs_div.sv
// ----------------------------------------------------------------------------
// ctcs_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ctcs_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ctcs_pkg::DV_NUM_W-1:0] numer,
   input  logic [ctcs_pkg::DV_DEN_W-1:0] denom,
   output logic [ctcs_pkg::DV_Q_W-1:0]   quot,
   output ctcs_pkg::unit_stat_type       stat
);
   import ctcs_pkg::*;

   localparam int CNT_W = $clog2(DV_NUM_W + 1);

   logic [DV_NUM_W-1:0] num_ff, num_in, q_ff, q_in;
   logic [DV_DEN_W-1:0] den_ff, den_in;
   logic [DV_DEN_W:0]   rem_ff, rem_in, rem_t;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      rem_t   = {rem_ff[DV_DEN_W-1:0], num_ff[DV_NUM_W-1]};
      num_in  = num_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = numer;
         den_in  = denom;
         q_in    = '0;
         rem_in  = '0;
         cnt_in  = CNT_W'(DV_NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[DV_NUM_W-2:0], 1'b0};
         if (rem_t >= {1'b0, den_ff}) begin
            rem_in = rem_t - {1'b0, den_ff};
            q_in   = {q_ff[DV_NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_t;
            q_in   = {q_ff[DV_NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      q_ff   <= q_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign quot      = q_ff[DV_Q_W-1:0];
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

>>> sv/circle_tilemap_collision_step.sv
// ----------------------------------------------------------------------------
// circle_tilemap_collision_step
// circle against a solid tile map: tile writes and move steps with push-out
// ----------------------------------------------------------------------------
// After reset the block sweeps the 1024-entry tile map to empty, one entry a
// cycle, and takes no item until done (register writes are taken). A tile
// write item writes the map when taken, then posts its result. A move item
// sets up travel and window (distance, diagonal scale, position, bounds),
// then walks the cell window (up to 25 cells) one cell at a time through the
// single map port: an empty cell is read and checked, a solid cell adds the
// 23-step square root, a pushing cell the two 33-step divisions. One item is
// in work at a time; the result register lets an item in while a result waits.
module circle_tilemap_collision_step #(
   parameter int MAP_SIDE = ctcs_pkg::MAP_SIDE_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_opcode,
   input  logic [9:0]                         req_tile_index,
   input  logic                               req_tile_solid,
   input  logic signed [1:0]                  req_dir_x,
   input  logic signed [1:0]                  req_dir_y,
   input  logic                               req_fast,
   input  logic [15:0]                        req_time_step,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [20:0]                        rsp_pos_x,
   output logic [20:0]                        rsp_pos_y,
   output logic                               rsp_collided,
   input  logic                               csr_write,
   input  logic [ctcs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ctcs_pkg::CSR_DATA_W-1:0]    csr_data
);
   import ctcs_pkg::*;

   localparam int CW    = $clog2(MAP_SIDE + 1);
   localparam int LIN_W = $clog2(MAP_SIDE * MAP_SIDE) + 1;

   typedef enum logic [17:0] {
      S_CLEAR = 18'd1 << 0,
      S_IDLE  = 18'd1 << 1,
      S_DIST  = 18'd1 << 2,
      S_COMP  = 18'd1 << 3,
      S_POS   = 18'd1 << 4,
      S_WIN   = 18'd1 << 5,
      S_RD    = 18'd1 << 6,
      S_CHK   = 18'd1 << 7,
      S_SQX   = 18'd1 << 8,
      S_SQY   = 18'd1 << 9,
      S_SQS   = 18'd1 << 10,
      S_SQW   = 18'd1 << 11,
      S_OVX   = 18'd1 << 12,
      S_DWX   = 18'd1 << 13,
      S_DVY   = 18'd1 << 14,
      S_DWY   = 18'd1 << 15,
      S_NEXT  = 18'd1 << 16,
      S_DONE  = 18'd1 << 17
   } state_type;

   state_type state_ff, state_in;

   logic [ADDR_W-1:0]  clr_ff, clr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]   centre_x_ff, centre_x_in, centre_y_ff, centre_y_in;
   logic [RAD_W-1:0]   radius_ff, radius_in;
   logic [SPD_W-1:0]   spd_n_ff, spd_n_in, spd_f_ff, spd_f_in;

   logic signed [1:0]  dx_ff, dx_in, dy_ff, dy_in;
   logic [SPD_W-1:0]   speed_ff, speed_in;
   logic [DT_W-1:0]    dt_ff, dt_in;
   logic [DIST_W-1:0]  dist_ff, dist_in, comp_ff, comp_in;
   logic [POS_W-1:0]   nx_ff, nx_in, ny_ff, ny_in;
   logic [CW-1:0]      lox_ff, lox_in, hix_ff, hix_in, hiy_ff, hiy_in;
   logic [CW-1:0]      x_ff, x_in, y_ff, y_in;
   logic signed [COORD_W-1:0] rx_ff, rx_in, ry_ff, ry_in;
   logic [SQ_IN_W-1:0] sqx_ff, sqx_in, sum_ff, sum_in;
   logic [RAD_W-1:0]   ov_ff, ov_in;
   logic [DV_Q_W-1:0]  px_ff, px_in;
   logic               coll_ff, coll_in;
   logic [POS_W-1:0]   rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic               rsp_c_ff, rsp_c_in;

   mem_req_type        mem_req;
   logic               mem_rd;
   logic               sq_start, dv_start;
   logic [SQ_ROOT_W-1:0] sq_root;
   logic [DV_NUM_W-1:0]  dv_num;
   logic [DV_Q_W-1:0]    dv_q;
   unit_stat_type      sq_stat, dv_stat;

   logic               req_acc;
   logic [SPD_W+DT_W-1:0] dprod;
   logic [19:0]        dshift;
   logic [32:0]        cprod;
   logic signed [COORD_W-1:0] cx_s, cy_s, cm_s, px_s, py_s;
   logic [POS_W-1:0]   cold_x, cold_y;
   logic [4:0]         cxo, cyo, txc, tyc, mnx, mxx, mny, mxy;
   logic [WIN_W-1:0]   wlox, wloy, whix, whiy;
   logic [LIN_W-1:0]   lin;
   logic signed [COORD_W-1:0] cl_lo, cl_hi, qx, qy, ax, ay;
   logic [SQ_IN_W-1:0] sq_prod;
   logic [SQ_ROOT_W-1:0] sq_a;
   logic signed [COORD_W-1:0] ov_s;
   logic [15:0]        mul_a, mul_b;
   logic [31:0]        mul_p;

   ctcs_tile_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (mem_rd)
   );

   ctcs_isqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (sum_ff),
      .root     (sq_root),
      .stat     (sq_stat)
   );

   ctcs_div u_div (
      .clock (clock),
      .reset (reset),
      .start (dv_start),
      .numer (dv_num),
      .denom (sq_root[DV_DEN_W-1:0]),
      .quot  (dv_q),
      .stat  (dv_stat)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_acc   = req_valid && !req_stall;

   // shared arithmetic
   assign dprod  = speed_ff * dt_ff;
   assign dshift = dprod[SPD_W+DT_W-1:8];
   assign cprod  = dist_ff * INV_SQRT2 + 33'd32768;
   assign ax     = (rx_ff < 0) ? -rx_ff : rx_ff;
   assign ay     = (ry_ff < 0) ? -ry_ff : ry_ff;
   assign sq_a   = (state_ff == S_SQY) ? ay[SQ_ROOT_W-1:0] : ax[SQ_ROOT_W-1:0];
   assign sq_prod = sq_a * sq_a;
   assign ov_s   = $signed({{(COORD_W-RAD_W){1'b0}}, radius_ff})
                 - $signed({{(COORD_W-SQ_ROOT_W){1'b0}}, sq_root});
   assign mul_a  = (state_ff == S_DVY) ? ay[15:0] : ax[15:0];
   assign mul_b  = (state_ff == S_DVY) ? ov_ff : ov_s[15:0];
   assign mul_p  = mul_a * mul_b;
   assign dv_num = {1'b0, mul_p} + {{(DV_NUM_W-15){1'b0}}, sq_root[15:1]};

   always_comb begin
      cold_x = centre_x_ff - HALF_TILE;
      cold_y = centre_y_ff - HALF_TILE;
      cxo = (centre_x_ff >= HALF_TILE) ? cold_x[20:16] : 5'd0;
      cyo = (centre_y_ff >= HALF_TILE) ? cold_y[20:16] : 5'd0;
      txc = nx_ff[20:16];
      tyc = ny_ff[20:16];
      mnx = (cxo < txc) ? cxo : txc;
      mxx = (cxo > txc) ? cxo : txc;
      mny = (cyo < tyc) ? cyo : tyc;
      mxy = (cyo > tyc) ? cyo : tyc;
      wlox = (mnx == 5'd0) ? '0 : WIN_W'(mnx) - 1'b1;
      wloy = (mny == 5'd0) ? '0 : WIN_W'(mny) - 1'b1;
      whix = WIN_W'(mxx) + WIN_W'(2);
      whiy = WIN_W'(mxy) + WIN_W'(2);
      if (whix > WIN_W'(MAP_SIDE)) whix = WIN_W'(MAP_SIDE);
      if (whiy > WIN_W'(MAP_SIDE)) whiy = WIN_W'(MAP_SIDE);
   end

   assign lin = LIN_W'(y_ff) * LIN_W'(MAP_SIDE) + LIN_W'(x_ff);

   always_comb begin
      cx_s  = $signed({{(COORD_W-POS_W){1'b0}}, nx_ff});
      cy_s  = $signed({{(COORD_W-POS_W){1'b0}}, ny_ff});
      cm_s  = $signed({{(COORD_W-DIST_W){1'b0}}, comp_ff});
      px_s  = $signed({{(COORD_W-DV_Q_W){1'b0}}, px_ff});
      py_s  = $signed({{(COORD_W-DV_Q_W){1'b0}}, dv_q});
      cl_lo = $signed(COORD_W'(x_ff) << 16);
      cl_hi = $signed((COORD_W'(x_ff) + COORD_W'(1)) << 16);
      qx    = (cx_s < cl_lo) ? cl_lo : ((cx_s > cl_hi) ? cl_hi : cx_s);
      cl_lo = $signed(COORD_W'(y_ff) << 16);
      cl_hi = $signed((COORD_W'(y_ff) + COORD_W'(1)) << 16);
      qy    = (cy_s < cl_lo) ? cl_lo : ((cy_s > cl_hi) ? cl_hi : cy_s);
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      centre_x_in  = centre_x_ff;
      centre_y_in  = centre_y_ff;
      radius_in    = radius_ff;
      spd_n_in     = spd_n_ff;
      spd_f_in     = spd_f_ff;
      dx_in = dx_ff;       dy_in = dy_ff;
      speed_in = speed_ff; dt_in = dt_ff;
      dist_in = dist_ff;   comp_in = comp_ff;
      nx_in = nx_ff;       ny_in = ny_ff;
      lox_in = lox_ff;     hix_in = hix_ff;   hiy_in = hiy_ff;
      x_in = x_ff;         y_in = y_ff;
      rx_in = rx_ff;       ry_in = ry_ff;
      sqx_in = sqx_ff;     sum_in = sum_ff;
      ov_in = ov_ff;       px_in = px_ff;     coll_in = coll_ff;
      rsp_x_in = rsp_x_ff; rsp_y_in = rsp_y_ff; rsp_c_in = rsp_c_ff;
      mem_req.we    = 1'b0;
      mem_req.addr  = lin[ADDR_W-1:0];
      mem_req.wdata = 1'b0;
      sq_start = 1'b0;
      dv_start = 1'b0;

      if (csr_write) begin
         unique case (csr_index)
            CSR_RADIUS:     radius_in = csr_data[RAD_W-1:0];
            CSR_SPEED_NORM: spd_n_in  = csr_data[SPD_W-1:0];
            CSR_SPEED_FAST: spd_f_in  = csr_data[SPD_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_CLEAR: begin
            mem_req.we   = 1'b1;
            mem_req.addr = clr_ff;
            clr_in       = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(MAP_CELLS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_acc) begin
               nx_in    = centre_x_ff;
               ny_in    = centre_y_ff;
               coll_in  = 1'b0;
               dx_in    = dir_of(req_dir_x);
               dy_in    = dir_of(req_dir_y);
               speed_in = req_fast ? spd_f_ff : spd_n_ff;
               dt_in    = req_time_step;
               if (req_opcode == OP_TILE) begin
                  mem_req.we    = 1'b1;
                  mem_req.addr  = req_tile_index;
                  mem_req.wdata = req_tile_solid;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_DIST;
               end
            end
         end
         S_DIST: begin
            dist_in  = (dshift > 20'(ONE_TILE)) ? ONE_TILE : dshift[DIST_W-1:0];
            state_in = S_COMP;
         end
         S_COMP: begin
            comp_in  = (dx_ff != 2'sb00 && dy_ff != 2'sb00) ? cprod[32:16] : dist_ff;
            state_in = S_POS;
         end
         S_POS: begin
            if (dx_ff == 2'sb01) nx_in = sat_pos(cx_s + cm_s);
            else if (dx_ff == 2'sb11) nx_in = sat_pos(cx_s - cm_s);
            if (dy_ff == 2'sb01) ny_in = sat_pos(cy_s + cm_s);
            else if (dy_ff == 2'sb11) ny_in = sat_pos(cy_s - cm_s);
            state_in = S_WIN;
         end
         S_WIN: begin
            lox_in = wlox[CW-1:0];
            hix_in = whix[CW-1:0];
            hiy_in = whiy[CW-1:0];
            x_in   = wlox[CW-1:0];
            y_in   = wloy[CW-1:0];
            state_in = (wlox >= whix || wloy >= whiy) ? S_DONE : S_RD;
         end
         S_RD: begin
            state_in = (lin < LIN_W'(MAP_CELLS)) ? S_CHK : S_NEXT;
         end
         S_CHK: begin
            rx_in    = qx - cx_s;
            ry_in    = qy - cy_s;
            state_in = mem_rd ? S_SQX : S_NEXT;
         end
         S_SQX: begin
            sqx_in   = sq_prod;
            state_in = S_SQY;
         end
         S_SQY: begin
            sum_in   = sqx_ff + sq_prod;
            state_in = S_SQS;
         end
         S_SQS: begin
            if (sum_ff == '0) begin
               state_in = S_NEXT;
            end else begin
               sq_start = 1'b1;
               state_in = S_SQW;
            end
         end
         S_SQW: begin
            if (sq_stat.done) state_in = S_OVX;
         end
         S_OVX: begin
            if (ov_s <= 0) begin
               state_in = S_NEXT;
            end else begin
               ov_in    = ov_s[RAD_W-1:0];
               dv_start = 1'b1;
               state_in = S_DWX;
            end
         end
         S_DWX: begin
            if (dv_stat.done) begin
               px_in    = dv_q;
               state_in = S_DVY;
            end
         end
         S_DVY: begin
            dv_start = 1'b1;
            state_in = S_DWY;
         end
         S_DWY: begin
            if (dv_stat.done) begin
               nx_in    = sat_pos((rx_ff < 0) ? cx_s + px_s : cx_s - px_s);
               ny_in    = sat_pos((ry_ff < 0) ? cy_s + py_s : cy_s - py_s);
               coll_in  = 1'b1;
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            if ((CW+1)'(x_ff) + 1'b1 < (CW+1)'(hix_ff)) begin
               x_in     = x_ff + 1'b1;
               state_in = S_RD;
            end else if ((CW+1)'(y_ff) + 1'b1 < (CW+1)'(hiy_ff)) begin
               x_in     = lox_ff;
               y_in     = y_ff + 1'b1;
               state_in = S_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_x_in     = nx_ff;
               rsp_y_in     = ny_ff;
               rsp_c_in     = coll_ff;
               centre_x_in  = nx_ff;
               centre_y_in  = ny_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         centre_x_ff  <= CENTRE_RESET;
         centre_y_ff  <= CENTRE_RESET;
         radius_ff    <= RADIUS_RESET;
         spd_n_ff     <= SPD_N_RESET;
         spd_f_ff     <= SPD_F_RESET;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         centre_x_ff  <= centre_x_in;
         centre_y_ff  <= centre_y_in;
         radius_ff    <= radius_in;
         spd_n_ff     <= spd_n_in;
         spd_f_ff     <= spd_f_in;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff <= dx_in;       dy_ff <= dy_in;
      speed_ff <= speed_in; dt_ff <= dt_in;
      dist_ff <= dist_in;   comp_ff <= comp_in;
      nx_ff <= nx_in;       ny_ff <= ny_in;
      lox_ff <= lox_in;     hix_ff <= hix_in;   hiy_ff <= hiy_in;
      x_ff <= x_in;         y_ff <= y_in;
      rx_ff <= rx_in;       ry_ff <= ry_in;
      sqx_ff <= sqx_in;     sum_ff <= sum_in;
      ov_ff <= ov_in;       px_ff <= px_in;     coll_ff <= coll_in;
      rsp_x_ff <= rsp_x_in; rsp_y_ff <= rsp_y_in; rsp_c_ff <= rsp_c_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_pos_x    = rsp_x_ff;
   assign rsp_pos_y    = rsp_y_ff;
   assign rsp_collided = rsp_c_ff;

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == S_DONE))
      else $error("result raised outside the done state");

   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(sq_stat.busy && dv_stat.busy))
      else $error("square root and divider busy together");

   a_div_after_root: assert property (@(posedge clock) disable iff (reset)
      dv_start |-> (state_ff == S_OVX || state_ff == S_DVY) && !sq_stat.busy)
      else $error("divider started while the root is not settled");

   a_clear_no_item: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |=> !rsp_valid || $past(rsp_valid))
      else $error("result produced during map clear");

endmodule
